// ===== rtl/core/lsfl_pkg.sv =====
package lsfl_pkg;

    // Default pool size
    localparam int POOL_NODES_DEF = 32;

    // Item payload widths
    localparam int DATA_W = 32;

    typedef logic [1:0]        opcode_t;
    typedef logic [1:0]        status_t;
    typedef logic [DATA_W-1:0] data_t;

    // Operation codes
    localparam opcode_t OP_PUSH  = 2'd0;
    localparam opcode_t OP_POP   = 2'd1;
    localparam opcode_t OP_CLEAR = 2'd2;

    // Result status codes
    localparam status_t ST_DONE  = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;

    // Popped value on an empty stack
    localparam data_t EMPTY_VALUE = '1;

endpackage

// ===== rtl/core/linked_stack_free_list.sv =====
// Linked stack in a pool of POOL_NODES nodes with a free list. Raise start for one
// cycle while busy is low to hand in an item (opcode 0 push, 1 pop, 2 clear). Every
// item gives exactly one result, shown for one cycle with done high; the receiver
// cannot stall it. Push and pop pass through the S_PUSH or S_POP state between accept
// and done (one read of the link memory, then the write-back), while a full push, an
// empty pop, a clear of an empty stack or an unused opcode raises done in the cycle
// after accept. Clear walks the stack one node per cycle through the link memory.
// A new item can be accepted in the cycle that done is high. No clearing pass after
// reset: nodes not yet taken from the pool since reset are tracked by a watermark,
// so the block is ready at once.
module linked_stack_free_list #(
    parameter int POOL_NODES = lsfl_pkg::POOL_NODES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  lsfl_pkg::opcode_t opcode,
    input  lsfl_pkg::data_t  push_value,
    output logic             done,
    output lsfl_pkg::data_t  popped_value,
    output lsfl_pkg::status_t status
);
    import lsfl_pkg::*;

    localparam int ADDR_W = $clog2(POOL_NODES);
    localparam int IDX_W  = $clog2(POOL_NODES + 1);
    localparam logic [IDX_W-1:0] NULL_IDX = IDX_W'(POOL_NODES);
    localparam logic [IDX_W-1:0] TOP_IDX  = IDX_W'(POOL_NODES - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PUSH,
        S_POP,
        S_CLEAR
    } state_t;

    state_t           state_reg;
    logic [IDX_W-1:0] free_head_reg;
    logic [IDX_W-1:0] top_reg;
    logic [IDX_W-1:0] fresh_reg;     // nodes below this were never written
    data_t            arg_reg;
    logic             done_reg;
    data_t            popped_reg;
    status_t          status_reg;

    logic             link_we;
    logic [ADDR_W-1:0] link_waddr;
    logic [IDX_W-1:0] link_wdata;
    logic [ADDR_W-1:0] link_raddr;
    logic [IDX_W-1:0] link_rd;
    logic             val_we;
    data_t            val_rd;
    logic [IDX_W-1:0] push_link;
    logic             free_fresh;

    // Link of the free head: untouched nodes still chain to the next lower index
    assign free_fresh = free_head_reg < fresh_reg;
    always_comb
    begin
        if (!free_fresh)
        begin
            push_link = link_rd;
        end
        else if (free_head_reg == '0)
        begin
            push_link = NULL_IDX;
        end
        else
        begin
            push_link = free_head_reg - 1'b1;
        end
    end

    // Memory port control
    always_comb
    begin
        link_we    = 1'b0;
        val_we     = 1'b0;
        link_waddr = top_reg[ADDR_W-1:0];
        link_wdata = free_head_reg;
        link_raddr = top_reg[ADDR_W-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (opcode == OP_PUSH)
                begin
                    link_raddr = free_head_reg[ADDR_W-1:0];
                end
            end
            S_PUSH:
            begin
                link_we    = 1'b1;
                val_we     = 1'b1;
                link_waddr = free_head_reg[ADDR_W-1:0];
                link_wdata = top_reg;
            end
            S_POP:
            begin
                link_we = 1'b1;
            end
            S_CLEAR:
            begin
                // give back the top node, fetch the link of the next one
                link_we    = 1'b1;
                link_raddr = link_rd[ADDR_W-1:0];
            end
            default:
            begin
                link_we = 1'b0;
            end
        endcase
    end

    lsfl_ram #(
        .WIDTH (IDX_W),
        .DEPTH (POOL_NODES)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rd)
    );

    lsfl_ram #(
        .WIDTH (DATA_W),
        .DEPTH (POOL_NODES)
    ) u_value_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (free_head_reg[ADDR_W-1:0]),
        .wdata (arg_reg),
        .raddr (top_reg[ADDR_W-1:0]),
        .rdata (val_rd)
    );

    // Sequencer, list heads and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_head_reg <= TOP_IDX;
            top_reg       <= NULL_IDX;
            fresh_reg     <= NULL_IDX;
            arg_reg       <= '0;
            done_reg      <= 1'b0;
            popped_reg    <= '0;
            status_reg    <= ST_DONE;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        popped_reg <= '0;
                        status_reg <= ST_DONE;
                        arg_reg    <= push_value;
                        unique case (opcode)
                            OP_PUSH:
                            begin
                                if (free_head_reg < NULL_IDX)
                                begin
                                    state_reg <= S_PUSH;
                                end
                                else
                                begin
                                    status_reg <= ST_FULL;
                                    done_reg   <= 1'b1;
                                end
                            end
                            OP_POP:
                            begin
                                if (top_reg < NULL_IDX)
                                begin
                                    state_reg <= S_POP;
                                end
                                else
                                begin
                                    popped_reg <= EMPTY_VALUE;
                                    status_reg <= ST_EMPTY;
                                    done_reg   <= 1'b1;
                                end
                            end
                            OP_CLEAR:
                            begin
                                if (top_reg < NULL_IDX)
                                begin
                                    state_reg <= S_CLEAR;
                                end
                                else
                                begin
                                    done_reg <= 1'b1;
                                end
                            end
                            default:
                            begin
                                done_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                S_PUSH:
                begin
                    free_head_reg <= push_link;
                    top_reg       <= free_head_reg;
                    if (free_fresh)
                    begin
                        fresh_reg <= fresh_reg - 1'b1;
                    end
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_POP:
                begin
                    popped_reg    <= val_rd;
                    top_reg       <= link_rd;
                    free_head_reg <= top_reg;
                    done_reg      <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                S_CLEAR:
                begin
                    free_head_reg <= top_reg;
                    if (link_rd < NULL_IDX)
                    begin
                        top_reg <= link_rd;
                    end
                    else
                    begin
                        top_reg   <= NULL_IDX;
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy         = state_reg != S_IDLE;
    assign done         = done_reg;
    assign popped_value = popped_reg;
    assign status       = status_reg;

`ifndef SYNTHESIS
    // A result is only shown once the sequencer is back at rest
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !(done && busy))
        else $error("result strobe while busy");

    // Every accepted item either answers at once or starts a memory pass
    a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("accepted item neither answered nor started");

    // The never-written watermark only moves down
    a_fresh_down: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg <= $past(fresh_reg))
        else $error("watermark moved up");

    // A node is never at the head of both lists
    a_heads_apart: assert property (@(posedge clk) disable iff (!rst_n)
        (free_head_reg < NULL_IDX && top_reg < NULL_IDX) |-> free_head_reg != top_reg)
        else $error("free head and stack top are the same node");
`endif

endmodule

// ===== rtl/core/lsfl_ram.sv =====
module lsfl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
